@@ hdl/compiled_automaton_matcher_top_defines.svh @@
// Assertion macros shared by the matcher RTL.
`ifndef COMPILED_AUTOMATON_MATCHER_TOP_DEFINES_SVH
`define COMPILED_AUTOMATON_MATCHER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define CAM_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("assertion failed");
`define CAM_ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define CAM_ASSERT(label, prop)
`define CAM_ASSERT_ALWAYS(label, prop)
`endif

`endif

@@ hdl/cam_pkg.sv @@
// Types and constants of the compiled automaton matcher.
package cam_pkg;

	localparam int TABLE_DEPTH_DEF = 4096;
	localparam int ADDR_IN_W       = 12;
	localparam int BYTE_W          = 8;
	localparam int COUNT_W         = 7;
	localparam int VALUE_W         = 32;
	localparam int FINAL_IDX       = 7;
	localparam int START_ADDR      = 3;
	localparam logic [BYTE_W-1:0] ANNOT_MARK = 8'h41;

	typedef enum logic [1:0] {
		KIND_WRITE  = 2'd0,
		KIND_SYMBOL = 2'd1,
		KIND_END    = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_HEAD,
		ST_SKIP,
		ST_TSYM,
		ST_TVLI0,
		ST_TVLI,
		ST_END_HEAD,
		ST_RVAL,
		ST_EMIT
	} fsm_t;

	typedef struct packed {
		logic               valid;
		logic               matched;
		logic [VALUE_W-1:0] value;
	} res_t;

endpackage

@@ hdl/cam_table.sv @@
// Automaton table memory: one write port, one registered read port.
module cam_table #(
	parameter int TABLE_DEPTH = cam_pkg::TABLE_DEPTH_DEF,
	localparam int AW = $clog2(TABLE_DEPTH)
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [cam_pkg::BYTE_W-1:0]  wdata,
	input  logic [AW-1:0]               raddr,
	output logic [cam_pkg::BYTE_W-1:0]  rdata
);

	logic [cam_pkg::BYTE_W-1:0] mem [TABLE_DEPTH];
	logic [cam_pkg::BYTE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ hdl/cam_walker.sv @@
// Sequencer that walks the automaton table one byte per cycle.
`include "compiled_automaton_matcher_top_defines.svh"

module cam_walker #(
	parameter int TABLE_DEPTH = cam_pkg::TABLE_DEPTH_DEF,
	localparam int AW = $clog2(TABLE_DEPTH)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic [1:0]                    kind,
	input  logic [cam_pkg::ADDR_IN_W-1:0] table_address,
	input  logic [cam_pkg::BYTE_W-1:0]    table_byte,
	input  logic [cam_pkg::BYTE_W-1:0]    symbol,
	output logic                          we,
	output logic [AW-1:0]                 waddr,
	output logic [cam_pkg::BYTE_W-1:0]    wdata,
	output logic [AW-1:0]                 raddr,
	input  logic [cam_pkg::BYTE_W-1:0]    rdata,
	input  logic                          out_free,
	output cam_pkg::res_t                 res
);

	localparam logic [AW-1:0] START_AW = AW'(cam_pkg::START_ADDR);
	localparam logic [AW-1:0] VCNT_MAX = AW'(TABLE_DEPTH - 1);
	localparam logic [AW-1:0] ONE_AW   = AW'(1);

	cam_pkg::fsm_t                    fsm_q, fsm_d;
	logic [AW-1:0]                    cur_q, cur_d;
	logic                             failed_q, failed_d;
	logic [AW-1:0]                    ptr_q, ptr_d;
	logic [AW-1:0]                    at_q, at_d;
	logic [cam_pkg::COUNT_W-1:0]      cnt_q, cnt_d;
	logic [AW-1:0]                    vcnt_q, vcnt_d;
	logic [cam_pkg::VALUE_W-1:0]      acc_q, acc_d;
	logic [cam_pkg::BYTE_W-1:0]       sym_q, sym_d;
	logic                             rm_q, rm_d;
	logic [cam_pkg::VALUE_W-1:0]      rv_q, rv_d;
	logic                             annot_q;
	logic                             accept;
	logic [cam_pkg::VALUE_W-1:0]      acc_next;
	logic                             vli_last;

	assign item_stall = (fsm_q != cam_pkg::ST_IDLE);
	assign accept     = item_valid && !item_stall;
	assign we         = accept && (cam_pkg::kind_t'(kind) == cam_pkg::KIND_WRITE);
	assign waddr      = AW'(table_address);
	assign wdata      = table_byte;

	assign acc_next = {acc_q[cam_pkg::VALUE_W-cam_pkg::COUNT_W-1:0],
		rdata[cam_pkg::COUNT_W-1:0]};
	assign vli_last = !rdata[cam_pkg::FINAL_IDX] || (vcnt_q == VCNT_MAX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q    <= cam_pkg::ST_IDLE;
			cur_q    <= START_AW;
			failed_q <= 1'b0;
			annot_q  <= 1'b0;
		end else begin
			fsm_q    <= fsm_d;
			cur_q    <= cur_d;
			failed_q <= failed_d;
			if (we && (waddr == '0)) begin
				annot_q <= (table_byte == cam_pkg::ANNOT_MARK);
			end
		end
	end

	always_ff @(posedge clk) begin
		ptr_q  <= ptr_d;
		at_q   <= at_d;
		cnt_q  <= cnt_d;
		vcnt_q <= vcnt_d;
		acc_q  <= acc_d;
		sym_q  <= sym_d;
		rm_q   <= rm_d;
		rv_q   <= rv_d;
	end

	always_comb begin
		fsm_d    = fsm_q;
		cur_d    = cur_q;
		failed_d = failed_q;
		ptr_d    = ptr_q + ONE_AW;
		at_d     = at_q;
		cnt_d    = cnt_q;
		vcnt_d   = vcnt_q + ONE_AW;
		acc_d    = acc_next;
		sym_d    = sym_q;
		rm_d     = rm_q;
		rv_d     = rv_q;
		raddr    = ptr_q;
		res      = '0;
		case (fsm_q)
			cam_pkg::ST_IDLE: begin
				raddr = cur_q;
				ptr_d = cur_q + ONE_AW;
				sym_d = symbol;
				if (accept) begin
					case (cam_pkg::kind_t'(kind))
						cam_pkg::KIND_SYMBOL: begin
							if (!failed_q) begin
								fsm_d = cam_pkg::ST_HEAD;
							end
						end
						cam_pkg::KIND_END: begin
							if (failed_q) begin
								rm_d  = 1'b0;
								rv_d  = '0;
								fsm_d = cam_pkg::ST_EMIT;
							end else begin
								fsm_d = cam_pkg::ST_END_HEAD;
							end
						end
						default: begin
						end
					endcase
				end
			end
			cam_pkg::ST_HEAD: begin
				cnt_d  = rdata[cam_pkg::COUNT_W-1:0];
				vcnt_d = '0;
				if (rdata[cam_pkg::COUNT_W-1:0] == '0) begin
					failed_d = 1'b1;
					fsm_d    = cam_pkg::ST_IDLE;
				end else if (annot_q && rdata[cam_pkg::FINAL_IDX]) begin
					fsm_d = cam_pkg::ST_SKIP;
				end else begin
					fsm_d = cam_pkg::ST_TSYM;
				end
			end
			cam_pkg::ST_SKIP: begin
				if (vli_last) begin
					vcnt_d = '0;
					if (cnt_q == '0) begin
						failed_d = 1'b1;
						fsm_d    = cam_pkg::ST_IDLE;
					end else begin
						fsm_d = cam_pkg::ST_TSYM;
					end
				end
			end
			cam_pkg::ST_TSYM: begin
				cnt_d  = cnt_q - 1'b1;
				vcnt_d = '0;
				if ((rdata == '0) || (rdata == sym_q)) begin
					fsm_d = cam_pkg::ST_TVLI0;
				end else begin
					fsm_d = cam_pkg::ST_SKIP;
				end
			end
			cam_pkg::ST_TVLI0: begin
				at_d  = ptr_q - ONE_AW;
				acc_d = cam_pkg::VALUE_W'(rdata[cam_pkg::COUNT_W-1:0]);
				if (rdata == '0) begin
					fsm_d = cam_pkg::ST_IDLE;
				end else if (!rdata[cam_pkg::FINAL_IDX]) begin
					cur_d = ptr_q - ONE_AW + AW'(rdata[cam_pkg::COUNT_W-1:0]);
					fsm_d = cam_pkg::ST_IDLE;
				end else begin
					fsm_d = cam_pkg::ST_TVLI;
				end
			end
			cam_pkg::ST_TVLI: begin
				if (vli_last) begin
					cur_d = at_q + AW'(acc_next);
					fsm_d = cam_pkg::ST_IDLE;
				end
			end
			cam_pkg::ST_END_HEAD: begin
				acc_d  = '0;
				vcnt_d = '0;
				if (!rdata[cam_pkg::FINAL_IDX]) begin
					rm_d  = 1'b0;
					rv_d  = '0;
					fsm_d = cam_pkg::ST_EMIT;
				end else if (!annot_q) begin
					rm_d  = 1'b1;
					rv_d  = '0;
					fsm_d = cam_pkg::ST_EMIT;
				end else begin
					fsm_d = cam_pkg::ST_RVAL;
				end
			end
			cam_pkg::ST_RVAL: begin
				if (vli_last) begin
					rm_d  = 1'b1;
					rv_d  = acc_next;
					fsm_d = cam_pkg::ST_EMIT;
				end
			end
			cam_pkg::ST_EMIT: begin
				if (out_free) begin
					res.valid   = 1'b1;
					res.matched = rm_q;
					res.value   = rv_q;
					cur_d       = START_AW;
					failed_d    = 1'b0;
					fsm_d       = cam_pkg::ST_IDLE;
				end
			end
			default: begin
				fsm_d = cam_pkg::ST_IDLE;
			end
		endcase
	end

	`CAM_ASSERT(a_res_room, res.valid |-> out_free)
	`CAM_ASSERT(a_restart, res.valid |=> ((cur_q == START_AW) && !failed_q))
	`CAM_ASSERT(a_nomatch_zero, (res.valid && !res.matched) |-> (res.value == '0))
	`CAM_ASSERT(a_tvli_count, (fsm_q == cam_pkg::ST_TVLI) |-> (vcnt_q != '0))
	`CAM_ASSERT(a_failed_rest, failed_q |-> ((fsm_q == cam_pkg::ST_IDLE) || (fsm_q == cam_pkg::ST_EMIT)))

endmodule

@@ hdl/compiled_automaton_matcher_top.sv @@
// Top level of the compiled automaton matcher.
//
// Input channel (item_valid / item_stall) carries kind, table_address,
// table_byte and symbol. A write item stores table_byte at table_address.
// Unless the string has already failed, a symbol item walks the current
// state in the table memory one byte per cycle: it reads the count byte,
// then the result, symbol and offset bytes scanned up to the taken
// transition. An end item reads the count byte and, for an annotated
// final state, the result value bytes, then loads the output stage;
// after a failed string it goes straight to the load. The single table
// read port paces these steps.
// Output channel (result_valid / result_stall) gives matched and
// result_value, one transfer per end item, from an output register. A
// stalled result holds; new items are taken meanwhile, and an end item
// waits before its own load only while the register is still held.
// Reset clears the match state to the first state after the header and
// the output valid; table contents are undefined until written, and no
// clearing pass runs.
`include "compiled_automaton_matcher_top_defines.svh"

module compiled_automaton_matcher_top #(
	parameter int TABLE_DEPTH = cam_pkg::TABLE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic [1:0]                    kind,
	input  logic [cam_pkg::ADDR_IN_W-1:0] table_address,
	input  logic [cam_pkg::BYTE_W-1:0]    table_byte,
	input  logic [cam_pkg::BYTE_W-1:0]    symbol,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic                          matched,
	output logic [cam_pkg::VALUE_W-1:0]   result_value
);

	localparam int AW = $clog2(TABLE_DEPTH);

	logic                        we;
	logic [AW-1:0]               waddr;
	logic [cam_pkg::BYTE_W-1:0]  wdata;
	logic [AW-1:0]               raddr;
	logic [cam_pkg::BYTE_W-1:0]  rdata;
	logic                        out_free;
	cam_pkg::res_t               res;
	logic                        result_valid_q;
	logic                        matched_q;
	logic [cam_pkg::VALUE_W-1:0] result_value_q;

	cam_table #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	cam_walker #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_walker (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.kind         (kind),
		.table_address(table_address),
		.table_byte   (table_byte),
		.symbol       (symbol),
		.we           (we),
		.waddr        (waddr),
		.wdata        (wdata),
		.raddr        (raddr),
		.rdata        (rdata),
		.out_free     (out_free),
		.res          (res)
	);

	assign out_free = !result_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (res.valid) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			matched_q      <= res.matched;
			result_value_q <= res.value;
		end
	end

	assign result_valid = result_valid_q;
	assign matched      = matched_q;
	assign result_value = result_value_q;

	`CAM_ASSERT(a_out_hold, (result_valid_q && result_stall) |=> result_valid_q)
	`CAM_ASSERT(a_out_value, (result_valid_q && !matched_q) |-> (result_value_q == '0))
	`CAM_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !result_valid_q)

endmodule
